[rtl/core/dq_pkg.sv]
// Shared types and constants for the double-ended queue.
package dq_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [2:0] MODE_PUSH_BACK  = 3'd0;
	localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
	localparam logic [2:0] MODE_POP_BACK   = 3'd2;
	localparam logic [2:0] MODE_POP_FRONT  = 3'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_POP_EMPTY = 2'd1;
	localparam logic [1:0] ST_PUSH_FULL = 2'd2;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_PUSH_FRONT,
		CELL_PUSH_BACK,
		CELL_POP_FRONT,
		CELL_POP_BACK
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic signed [31:0] value;
	} cell_cmd_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] front_value;
		logic signed [31:0] back_value;
		logic [4:0]         count;
		logic               is_empty;
		logic               is_full;
		logic [1:0]         status;
	} rsp_t;

endpackage

[rtl/core/double_ended_queue.sv]
// Top level of the double-ended queue: cell chain, count and result register.
//
// Usage:
//   Request channel (req_valid/req_stall/req): one transaction carries a mode
//   (push back, push front, pop back, pop front, query) and a signed value.
//   Response channel (rsp_valid/rsp_stall/rsp): exactly one transaction per
//   request, in order, with front and back values (-1 when empty), count,
//   empty and full flags and a status (ok, pop on empty, push on full).
//   Storage is a row of DEPTH cells; the front sits in the first cell and
//   pushes and pops at the front shift the whole row by one place.
//   A taken request sets pend_s1; the result register then loads from it.
//   Throughput: one request per cycle while rsp_stall is low, set by the
//   registered cell update followed by one result register stage.
//   Reset: arst_n empties the queue; no response is pending afterwards.
//   Stall: while rsp_stall holds a response, one more request is taken and
//   parked; req_stall then rises until the response register frees up.
module double_ended_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  dq_pkg::req_t  req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output dq_pkg::rsp_t  rsp
);
	import dq_pkg::*;

	logic signed [31:0] cell_data [DEPTH];
	logic [DEPTH-1:0]   cell_valid;
	logic [DEPTH:0]     valid_ext;
	cell_cmd_t          cmd;
	logic [CNT_W-1:0]   cnt_q;
	logic               req_acc;
	logic               full;
	logic               empty;
	logic [1:0]         status;
	logic               pend_s1;
	logic [1:0]         status_s1;
	logic               rsp_load;
	logic signed [31:0] back_sel;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	assign valid_ext = {1'b0, cell_valid};
	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign empty     = (cnt_q == '0);
	assign rsp_load  = pend_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = pend_s1 && !rsp_load;
	assign req_acc   = req_valid && !req_stall;

	always_comb begin
		cmd.op    = CELL_HOLD;
		cmd.value = req.value;
		status    = ST_OK;
		case (req.mode)
			MODE_PUSH_BACK: begin
				if (full)
					status = ST_PUSH_FULL;
				else
					cmd.op = CELL_PUSH_BACK;
			end
			MODE_PUSH_FRONT: begin
				if (full)
					status = ST_PUSH_FULL;
				else
					cmd.op = CELL_PUSH_FRONT;
			end
			MODE_POP_BACK: begin
				if (empty)
					status = ST_POP_EMPTY;
				else
					cmd.op = CELL_POP_BACK;
			end
			MODE_POP_FRONT: begin
				if (empty)
					status = ST_POP_EMPTY;
				else
					cmd.op = CELL_POP_FRONT;
			end
			default: ;
		endcase
		if (!req_acc)
			cmd.op = CELL_HOLD;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [31:0] l_data;
		logic               l_valid;
		logic signed [31:0] r_data;

		if (i == 0) begin : g_first
			assign l_data  = req.value;
			assign l_valid = 1'b1;
		end else begin : g_mid
			assign l_data  = cell_data[i-1];
			assign l_valid = cell_valid[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign r_data = '0;
		end else begin : g_inner
			assign r_data = cell_data[i+1];
		end

		dq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.left_data   (l_data),
			.left_valid  (l_valid),
			.right_data  (r_data),
			.right_valid (valid_ext[i+1]),
			.data_q      (cell_data[i]),
			.valid_q     (cell_valid[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (cmd.op)
				CELL_PUSH_FRONT, CELL_PUSH_BACK: cnt_q <= cnt_q + CNT_W'(1);
				CELL_POP_FRONT, CELL_POP_BACK:   cnt_q <= cnt_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (req_acc) begin
			pend_s1 <= 1'b1;
		end else if (rsp_load) begin
			pend_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc)
			status_s1 <= status;
	end

	// last occupied cell holds the back value
	always_comb begin
		back_sel = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (valid_ext[i] && !valid_ext[i+1])
				back_sel = back_sel | cell_data[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.front_value <= empty ? -32'sd1 : cell_data[0];
			rsp_q.back_value  <= empty ? -32'sd1 : back_sel;
			rsp_q.count       <= 5'(cnt_q);
			rsp_q.is_empty    <= empty;
			rsp_q.is_full     <= full;
			rsp_q.status      <= status_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_cnt_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == int'(cnt_q))
		else $error("count does not match occupied cells");

	a_cells_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((cell_valid + DEPTH'(1)) & cell_valid) == '0)
		else $error("occupied cells not packed at the front");

	a_pop_empty_holds: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && empty && (req.mode == MODE_POP_BACK || req.mode == MODE_POP_FRONT)
		|=> $stable(cell_valid) && $stable(cnt_q))
		else $error("pop on empty changed the queue");

	a_push_back_grows: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && !full && req.mode == MODE_PUSH_BACK
		|=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("push back did not grow the queue");

endmodule

[rtl/core/dq_cell.sv]
// One storage cell of the queue chain; shifts data with its neighbors.
module dq_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dq_pkg::cell_cmd_t        cmd,
	input  logic signed [31:0]       left_data,
	input  logic                     left_valid,
	input  logic signed [31:0]       right_data,
	input  logic                     right_valid,
	output logic signed [31:0]       data_q,
	output logic                     valid_q
);
	import dq_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				CELL_PUSH_FRONT: valid_q <= left_valid;
				CELL_PUSH_BACK: begin
					if (!valid_q && left_valid)
						valid_q <= 1'b1;
				end
				CELL_POP_FRONT: valid_q <= right_valid;
				CELL_POP_BACK: begin
					if (valid_q && !right_valid)
						valid_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_PUSH_FRONT: data_q <= left_data;
			CELL_PUSH_BACK: begin
				if (!valid_q && left_valid)
					data_q <= cmd.value;
			end
			CELL_POP_FRONT: data_q <= right_data;
			default: ;
		endcase
	end

endmodule
